// File: design/ilm_pkg.sv
// Shared types and constants for the interrupt latency monitor.
package ilm_pkg;

  localparam int RING_DEPTH = 32;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int TS_W       = 32;
  localparam int SUM_W      = 64;
  localparam int CPU_W      = 10;
  localparam int DL_W       = 16;
  localparam int LIMIT_W    = CPU_W + DL_W + 1;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic CMD_CAPTURE = 1'b0;
  localparam logic CMD_SERVICE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_US = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DEADLINE_US  = CFG_IDX_W'(1);

  localparam logic [CPU_W-1:0] CPU_RESET = CPU_W'(16);
  localparam logic [DL_W-1:0]  DL_RESET  = DL_W'(1000);

  typedef struct packed {
    logic            valid;
    logic            popped;
    logic            dropped;
    logic [TS_W-1:0] stamp;
  } ring_beat_t;

  typedef struct packed {
    logic            valid;
    logic            popped;
    logic            dropped;
    logic            missed;
    logic [TS_W-1:0] start;
    logic [TS_W-1:0] lat;
  } lat_beat_t;

  typedef struct packed {
    logic             popped;
    logic [TS_W-1:0]  start_timestamp;
    logic [TS_W-1:0]  latency_ticks;
    logic             deadline_missed;
    logic             dropped;
    logic [TS_W-1:0]  measured_count;
    logic [TS_W-1:0]  min_latency;
    logic [TS_W-1:0]  max_latency;
    logic [TS_W-1:0]  jitter;
    logic [SUM_W-1:0] total_latency;
    logic [TS_W-1:0]  missed_count;
    logic [TS_W-1:0]  overflow_total;
  } out_beat_t;

endpackage

// File: design/ilm_in_if.sv
// Input channel: command and timestamp beats.
interface ilm_in_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [ilm_pkg::TS_W-1:0]  timestamp;

  modport source (output valid, command, timestamp, input ready);
  modport sink   (input valid, command, timestamp, output ready);
endinterface

// File: design/ilm_out_if.sv
// Result channel: per-beat measurement and running statistics.
interface ilm_out_if;
  logic                      valid;
  logic                      ready;
  logic                      popped;
  logic [ilm_pkg::TS_W-1:0]  start_timestamp;
  logic [ilm_pkg::TS_W-1:0]  latency_ticks;
  logic                      deadline_missed;
  logic                      dropped;
  logic [ilm_pkg::TS_W-1:0]  measured_count;
  logic [ilm_pkg::TS_W-1:0]  min_latency;
  logic [ilm_pkg::TS_W-1:0]  max_latency;
  logic [ilm_pkg::TS_W-1:0]  jitter;
  logic [ilm_pkg::SUM_W-1:0] total_latency;
  logic [ilm_pkg::TS_W-1:0]  missed_count;
  logic [ilm_pkg::TS_W-1:0]  overflow_total;

  modport source (output valid, popped, start_timestamp, latency_ticks, deadline_missed,
                  dropped, measured_count, min_latency, max_latency, jitter, total_latency,
                  missed_count, overflow_total, input ready);
  modport sink   (input valid, popped, start_timestamp, latency_ticks, deadline_missed,
                  dropped, measured_count, min_latency, max_latency, jitter, total_latency,
                  missed_count, overflow_total, output ready);
endinterface

// File: design/ilm_cfg_if.sv
// Configuration write channel.
interface ilm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ilm_pkg::CFG_IDX_W-1:0]    reg_index;
  logic [ilm_pkg::CFG_DATA_W-1:0]   wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// File: design/ilm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ilm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/ilm_ring.sv
// Timestamp ring: index control, full/empty decision and ring memory.
module ilm_ring (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       command,
  input  logic [ilm_pkg::TS_W-1:0]   timestamp,
  input  logic                       s1_take,
  output ilm_pkg::ring_beat_t        s1,
  output logic [ilm_pkg::TS_W-1:0]   start_stamp
);

  logic [ilm_pkg::IDX_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt, wr_inc, rd_inc;
  ilm_pkg::ring_beat_t       s1_r, s1_nxt;
  logic                      acc, is_cap, full, empty, push, pop;

  assign wr_inc = (wr_r == ilm_pkg::IDX_W'(ilm_pkg::RING_DEPTH - 1)) ? '0 : wr_r + 1'b1;
  assign rd_inc = (rd_r == ilm_pkg::IDX_W'(ilm_pkg::RING_DEPTH - 1)) ? '0 : rd_r + 1'b1;

  assign in_ready = !s1_r.valid || s1_take;
  assign acc      = in_valid && in_ready;
  assign is_cap   = (command == ilm_pkg::CMD_CAPTURE);
  assign full     = (wr_inc == rd_r);
  assign empty    = (wr_r == rd_r);
  assign push     = acc && is_cap && !full;
  assign pop      = acc && !is_cap && !empty;

  assign wr_nxt = push ? wr_inc : wr_r;
  assign rd_nxt = pop ? rd_inc : rd_r;

  always_comb begin
    s1_nxt.valid   = in_valid;
    s1_nxt.popped  = pop;
    s1_nxt.dropped = acc && is_cap && full;
    s1_nxt.stamp   = timestamp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r       <= '0;
      rd_r       <= '0;
      s1_r.valid <= 1'b0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
      if (in_ready) begin
        s1_r <= s1_nxt;
      end
    end
  end

  ilm_ram #(
    .WIDTH (ilm_pkg::TS_W),
    .DEPTH (ilm_pkg::RING_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (push),
    .waddr (wr_r),
    .wdata (timestamp),
    .re    (pop),
    .raddr (rd_r),
    .rdata (start_stamp)
  );

  assign s1 = s1_r;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_r <= ilm_pkg::IDX_W'(ilm_pkg::RING_DEPTH - 1)) &&
    (rd_r <= ilm_pkg::IDX_W'(ilm_pkg::RING_DEPTH - 1)))
    else $error("ring index out of range");

endmodule

// File: design/ilm_stats.sv
// Latency, deadline check and running statistics, with the output register.
module ilm_stats (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ilm_pkg::ring_beat_t         s1,
  input  logic [ilm_pkg::TS_W-1:0]    start_stamp,
  output logic                        s1_take,
  input  logic [ilm_pkg::CPU_W-1:0]   ticks_per_us,
  input  logic [ilm_pkg::DL_W-1:0]    deadline_us,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ilm_pkg::out_beat_t          out_data
);

  localparam int TS_W  = ilm_pkg::TS_W;
  localparam int SUM_W = ilm_pkg::SUM_W;
  localparam int LIM_W = ilm_pkg::LIMIT_W;

  logic [LIM_W-1:0]   limit_r, limit_nxt;
  ilm_pkg::lat_beat_t s2_r, s2_nxt;
  logic               s2_take, upd, out_v_r;
  ilm_pkg::out_beat_t out_r, out_nxt;
  logic [TS_W-1:0]    lat1;

  logic [TS_W-1:0]  ev_r, ev_nxt, min_r, min_nxt, max_r, max_nxt;
  logic [TS_W-1:0]  prev_r, prev_nxt, jit_r, jit_nxt, miss_r, miss_nxt;
  logic [TS_W-1:0]  drop_r, drop_nxt, diff;
  logic [SUM_W-1:0] sum_r, sum_nxt;

  // (deadline_us + 1) * ticks_per_us; zero only when the check is off
  assign limit_nxt = LIM_W'({1'b0, deadline_us} + 17'd1) * LIM_W'(ticks_per_us);

  assign s2_take = !out_v_r || out_ready;
  assign s1_take = !s2_r.valid || s2_take;
  assign upd     = s2_r.valid && s2_take;

  assign lat1 = s1.stamp - start_stamp;

  always_comb begin
    s2_nxt.valid   = s1.valid;
    s2_nxt.popped  = s1.popped;
    s2_nxt.dropped = s1.dropped;
    s2_nxt.start   = s1.popped ? start_stamp : '0;
    s2_nxt.lat     = s1.popped ? lat1 : '0;
    s2_nxt.missed  = s1.popped && (limit_r != '0) && (lat1 >= TS_W'(limit_r));
  end

  assign diff = (s2_r.lat > prev_r) ? s2_r.lat - prev_r : prev_r - s2_r.lat;

  always_comb begin
    ev_nxt   = ev_r;
    sum_nxt  = sum_r;
    min_nxt  = min_r;
    max_nxt  = max_r;
    jit_nxt  = jit_r;
    prev_nxt = prev_r;
    miss_nxt = miss_r;
    drop_nxt = s2_r.dropped ? drop_r + 1'b1 : drop_r;
    if (s2_r.popped) begin
      ev_nxt   = ev_r + 1'b1;
      sum_nxt  = sum_r + SUM_W'(s2_r.lat);
      min_nxt  = (s2_r.lat < min_r) ? s2_r.lat : min_r;
      max_nxt  = (s2_r.lat > max_r) ? s2_r.lat : max_r;
      jit_nxt  = (ev_nxt > TS_W'(1)) ? diff : jit_r;
      prev_nxt = s2_r.lat;
      miss_nxt = s2_r.missed ? miss_r + 1'b1 : miss_r;
    end
  end

  always_comb begin
    out_nxt.popped          = s2_r.popped;
    out_nxt.start_timestamp = s2_r.start;
    out_nxt.latency_ticks   = s2_r.lat;
    out_nxt.deadline_missed = s2_r.missed;
    out_nxt.dropped         = s2_r.dropped;
    out_nxt.measured_count  = ev_nxt;
    out_nxt.min_latency     = min_nxt;
    out_nxt.max_latency     = max_nxt;
    out_nxt.jitter          = jit_nxt;
    out_nxt.total_latency   = sum_nxt;
    out_nxt.missed_count    = miss_nxt;
    out_nxt.overflow_total  = drop_nxt;
  end

  always_ff @(posedge clk) begin
    limit_r <= limit_nxt;
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
      out_v_r    <= 1'b0;
      ev_r       <= '0;
      sum_r      <= '0;
      min_r      <= '1;
      max_r      <= '0;
      jit_r      <= '0;
      prev_r     <= '0;
      miss_r     <= '0;
      drop_r     <= '0;
    end else begin
      if (s1_take) begin
        s2_r <= s2_nxt;
      end
      if (s2_take) begin
        out_v_r <= s2_r.valid;
        out_r   <= out_nxt;
      end
      if (upd) begin
        ev_r   <= ev_nxt;
        sum_r  <= sum_nxt;
        min_r  <= min_nxt;
        max_r  <= max_nxt;
        jit_r  <= jit_nxt;
        prev_r <= prev_nxt;
        miss_r <= miss_nxt;
        drop_r <= drop_nxt;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_pop_xor_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(out_r.popped && out_r.dropped))
    else $error("beat both popped and dropped");

  a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
    upd && s2_r.missed |=> miss_r == $past(miss_r) + 1'b1)
    else $error("missed deadline not counted");

  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_r.measured_count != '0) |-> out_r.min_latency <= out_r.max_latency)
    else $error("minimum above maximum");

endmodule

// File: design/interrupt_latency_monitor_core.sv
// Top level of the interrupt latency monitor.
// Usage:
//   in_ch  : one beat per event; command capture pushes timestamp into a
//            32-entry ring (31 usable), command service pops the oldest entry
//            and measures latency = timestamp - start, wrapping at 32 bits.
//   out_ch : exactly one beat per input beat, in order, carrying the
//            per-event fields and the running statistics after that event.
//   cfg_ch : register 0 clock ticks per microsecond, register 1 deadline_us;
//            always ready. Write only while no beat is in flight.
// Pipeline: an accepted input beat passes, in order, the ring memory read, the
//   latency/deadline stage and the statistics stage, each one registered.
// Throughput: one beat per cycle while out_ch is not stalled; the statistics
//   update is a read-modify-write of the counter registers in the last stage.
// Stall: out_ch.ready low holds the output register; the two inner stages
//   keep filling, so up to two more beats are taken before in_ch.ready drops.
// Reset: synchronous rst_n empties the ring and pipeline, clears counters,
//   sets minimum to all ones and loads the register reset values.
module interrupt_latency_monitor_core (
  input  logic              clk,
  input  logic              rst_n,
  ilm_in_if.sink            in_ch,
  ilm_out_if.source         out_ch,
  ilm_cfg_if.sink           cfg_ch
);

  logic [ilm_pkg::CPU_W-1:0] cpu_r;
  logic [ilm_pkg::DL_W-1:0]  dl_r;
  ilm_pkg::ring_beat_t       s1;
  logic [ilm_pkg::TS_W-1:0]  start_stamp;
  logic                      s1_take;
  ilm_pkg::out_beat_t        out_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_r <= ilm_pkg::CPU_RESET;
      dl_r  <= ilm_pkg::DL_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.reg_index == ilm_pkg::REG_TICKS_PER_US) begin
        cpu_r <= cfg_ch.wdata[ilm_pkg::CPU_W-1:0];
      end
      if (cfg_ch.reg_index == ilm_pkg::REG_DEADLINE_US) begin
        dl_r <= cfg_ch.wdata[ilm_pkg::DL_W-1:0];
      end
    end
  end

  ilm_ring u_ring (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .command     (in_ch.command),
    .timestamp   (in_ch.timestamp),
    .s1_take     (s1_take),
    .s1          (s1),
    .start_stamp (start_stamp)
  );

  ilm_stats u_stats (
    .clk           (clk),
    .rst_n         (rst_n),
    .s1            (s1),
    .start_stamp   (start_stamp),
    .s1_take       (s1_take),
    .ticks_per_us  (cpu_r),
    .deadline_us   (dl_r),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_data      (out_data)
  );

  assign out_ch.popped          = out_data.popped;
  assign out_ch.start_timestamp = out_data.start_timestamp;
  assign out_ch.latency_ticks   = out_data.latency_ticks;
  assign out_ch.deadline_missed = out_data.deadline_missed;
  assign out_ch.dropped         = out_data.dropped;
  assign out_ch.measured_count  = out_data.measured_count;
  assign out_ch.min_latency     = out_data.min_latency;
  assign out_ch.max_latency     = out_data.max_latency;
  assign out_ch.jitter          = out_data.jitter;
  assign out_ch.total_latency   = out_data.total_latency;
  assign out_ch.missed_count    = out_data.missed_count;
  assign out_ch.overflow_total  = out_data.overflow_total;

endmodule
